@@ rtl/lzd_pkg.sv @@
// shared types and constants for the lz77 byte decompressor
package lzd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int SIZE_W       = 24;
    localparam int COUNT_W      = WIN_AW + 1;
    localparam int LEN_W        = 5;
    localparam logic [3:0] LEN_BIAS = 4'd3;
    localparam logic [3:0] FLAG_BITS = 4'd8;

    // parser states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_FLAG,
        ST_TOKEN,
        ST_REF2,
        ST_COPY
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic ld_hdr1;
        logic ld_hdr2;
        logic ld_hdr3;
        logic ld_flag;
        logic take_lit;
        logic take_ref1;
        logic take_ref2;
        logic copy_run;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic flag_msb;
        logic flag_last;
        logic flag_empty;
        logic left_one;
        logic left_zero;
        logic hdr_zero;
        logic copy_busy;
        logic adv;
    } t_status;

endpackage

@@ rtl/lzd_ctrl.sv @@
// parser state machine of the lz77 byte decompressor
module lzd_ctrl import lzd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_stream_start,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input may be taken unless copying, or a literal waits on a full output
    always_comb begin
        o_in_ready = (r_state != ST_COPY) &&
                     (i_status.adv || !(r_state == ST_TOKEN && !i_status.flag_msb));
    end

    assign w_fire = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (w_fire && i_stream_start) begin
            o_cmd.start = 1'b1;
            n_state     = ST_HDR1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    n_state = ST_IDLE;
                end
                ST_HDR1: begin
                    if (w_fire) begin
                        o_cmd.ld_hdr1 = 1'b1;
                        n_state       = ST_HDR2;
                    end
                end
                ST_HDR2: begin
                    if (w_fire) begin
                        o_cmd.ld_hdr2 = 1'b1;
                        n_state       = ST_HDR3;
                    end
                end
                ST_HDR3: begin
                    if (w_fire) begin
                        o_cmd.ld_hdr3 = 1'b1;
                        n_state       = i_status.hdr_zero ? ST_IDLE : ST_FLAG;
                    end
                end
                ST_FLAG: begin
                    if (w_fire) begin
                        o_cmd.ld_flag = 1'b1;
                        n_state       = ST_TOKEN;
                    end
                end
                ST_TOKEN: begin
                    if (w_fire) begin
                        if (i_status.flag_msb) begin
                            o_cmd.take_ref1 = 1'b1;
                            n_state         = ST_REF2;
                        end else begin
                            o_cmd.take_lit = 1'b1;
                            priority if (i_status.left_one) begin
                                n_state = ST_IDLE;
                            end else if (i_status.flag_last) begin
                                n_state = ST_FLAG;
                            end else begin
                                n_state = ST_TOKEN;
                            end
                        end
                    end
                end
                ST_REF2: begin
                    if (w_fire) begin
                        o_cmd.take_ref2 = 1'b1;
                        n_state         = ST_COPY;
                    end
                end
                ST_COPY: begin
                    o_cmd.copy_run = 1'b1;
                    if (!i_status.copy_busy) begin
                        priority if (i_status.left_zero) begin
                            n_state = ST_IDLE;
                        end else if (i_status.flag_empty) begin
                            n_state = ST_FLAG;
                        end else begin
                            n_state = ST_TOKEN;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lzd_dpath.sv @@
// counters, history window, copy engine and output register
module lzd_dpath import lzd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_ready,
    output t_status    o_status,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_ref_error
);

    logic [7:0]        r_mem [WINDOW_DEPTH];
    logic [WIN_AW-1:0] r_wpos;
    logic [SIZE_W-1:0] r_left;
    logic [COUNT_W-1:0] r_prod;
    logic [7:0]        r_flag;
    logic [3:0]        r_flag_cnt;
    logic [7:0]        r_held;
    logic [COUNT_W-1:0] r_dist;
    logic [LEN_W-1:0]  r_issue_cnt;
    logic [WIN_AW-1:0] r_src;
    logic              r_rd_pend;
    logic [7:0]        r_rd_data;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_data;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_err;

    logic               w_adv;
    logic               w_rd_en;
    logic               w_emit;
    logic               w_err;
    logic [7:0]         w_data;
    logic [COUNT_W-1:0] w_dist;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_eff_len;

    assign w_adv = !r_out_valid || i_out_ready;

    // reference fields from held byte and second byte
    assign w_dist    = {1'b0, r_held[3:0], i_in_byte} + COUNT_W'(1);
    assign w_len     = LEN_W'(r_held[7:4]) + LEN_W'(LEN_BIAS);
    assign w_eff_len = (r_left < SIZE_W'(w_len)) ? r_left[LEN_W-1:0] : w_len;

    // copy reads and emitted byte
    assign w_rd_en = i_cmd.copy_run && (r_issue_cnt != '0) && w_adv;
    assign w_emit  = i_cmd.take_lit || (i_cmd.copy_run && r_rd_pend && w_adv);
    assign w_err   = !i_cmd.take_lit && (r_dist > r_prod);

    always_comb begin
        priority if (i_cmd.take_lit) begin
            w_data = i_in_byte;
        end else if (w_err) begin
            w_data = 8'd0;
        end else if (r_fwd_hit) begin
            w_data = r_fwd_data;
        end else begin
            w_data = r_rd_data;
        end
    end

    // status to controller
    always_comb begin
        o_status.flag_msb   = r_flag[7];
        o_status.flag_last  = (r_flag_cnt == 4'd1);
        o_status.flag_empty = (r_flag_cnt == 4'd0);
        o_status.left_one   = (r_left == SIZE_W'(1));
        o_status.left_zero  = (r_left == '0);
        o_status.hdr_zero   = ({i_in_byte, r_left[15:0]} == '0);
        o_status.copy_busy  = (r_issue_cnt != '0) || r_rd_pend;
        o_status.adv        = w_adv;
    end

    // history window
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_mem[r_wpos] <= w_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_src];
        end
    end

    // bypass when the read hits the slot being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_fwd_hit  <= w_emit && (r_src == r_wpos);
            r_fwd_data <= w_data;
        end
    end

    // copy source pointer and reference distance
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_ref1) begin
            r_held <= i_in_byte;
        end
        if (i_cmd.take_ref2) begin
            r_dist <= w_dist;
            r_src  <= r_wpos - w_dist[WIN_AW-1:0];
        end else if (w_rd_en) begin
            r_src <= r_src + WIN_AW'(1);
        end
    end

    // parser counters and copy control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= '0;
            r_left      <= '0;
            r_prod      <= '0;
            r_flag      <= '0;
            r_flag_cnt  <= '0;
            r_issue_cnt <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_wpos     <= '0;
                r_left     <= '0;
                r_prod     <= '0;
                r_flag     <= '0;
                r_flag_cnt <= '0;
            end
            if (i_cmd.ld_hdr1) begin
                r_left <= SIZE_W'(i_in_byte);
            end
            if (i_cmd.ld_hdr2) begin
                r_left[15:8] <= i_in_byte;
            end
            if (i_cmd.ld_hdr3) begin
                r_left[23:16] <= i_in_byte;
            end
            if (i_cmd.ld_flag) begin
                r_flag     <= i_in_byte;
                r_flag_cnt <= FLAG_BITS;
            end
            if (i_cmd.take_lit || i_cmd.take_ref1) begin
                r_flag     <= {r_flag[6:0], 1'b0};
                r_flag_cnt <= r_flag_cnt - 4'd1;
            end
            if (w_emit) begin
                r_wpos <= r_wpos + WIN_AW'(1);
                r_left <= r_left - SIZE_W'(1);
                if (!r_prod[COUNT_W-1]) begin
                    r_prod <= r_prod + COUNT_W'(1);
                end
            end
            if (i_cmd.take_ref2) begin
                r_issue_cnt <= w_eff_len;
            end else if (w_rd_en) begin
                r_issue_cnt <= r_issue_cnt - LEN_W'(1);
            end
            if (i_cmd.copy_run && w_adv) begin
                r_rd_pend <= w_rd_en;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_data;
            r_out_last <= (r_left == SIZE_W'(1));
            r_out_err  <= w_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_ref_error = r_out_err;

endmodule

@@ rtl/lz77_byte_decompressor.sv @@
// top level of the lz77 byte decompressor
// Input channel: one compressed byte per transaction (i_in_valid / o_in_ready),
// with i_stream_start high on the first header byte of a stream. A stream is a
// 4-byte header (type byte, then 24-bit size, low byte first) and then flag
// bytes, each followed by up to eight tokens taken MSB first.
// Output channel: one decompressed byte per transaction (o_out_valid /
// i_out_ready), with o_out_last on the byte that completes the size and
// o_ref_error (byte forced to zero) when a reference reaches before the stream.
// Header, flag and literal bytes are taken one per cycle, literals only while
// the output advances. A reference takes its two bytes, then holds the input
// while it copies n bytes, n being the copied length (up to 18), one per cycle
// as the output advances, set by the history window read. An accepted literal is
// output in the next cycle; a copied byte is registered at its window read first.
// A full output register stalls the copy engine and literal tokens; header and
// flag bytes are still taken.
// Reset clears the parser to idle, awaiting a stream start; the window contents
// are not cleared and need no clearing pass. Bytes after the size are dropped.
module lz77_byte_decompressor import lzd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_start,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_ref_error
);

    t_cmd    w_cmd;
    t_status w_status;

    // parser controller
    lzd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_stream_start (i_stream_start),
        .i_status       (w_status),
        .o_in_ready     (o_in_ready),
        .o_cmd          (w_cmd)
    );

    // datapath with history window
    lzd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_byte   (i_in_byte),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_ref_error (o_ref_error)
    );

endmodule

@@ test/tb_lz77_byte_decompressor.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the lz77 byte decompressor with a decode scoreboard
module tb_lz77_byte_decompressor import lzd_pkg::*; ();

    // one expected output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_out_byte;

    class lz_decode_board;
        // mirror of the decoder state
        logic [7:0]         hist [WINDOW_DEPTH];
        logic [WIN_AW-1:0]  wpos;
        logic [SIZE_W-1:0]  owed;
        logic [COUNT_W-1:0] made;
        logic [7:0]         flag_sr;
        logic [3:0]         flag_cnt;
        t_state             phase;
        logic [7:0]         ref_b0;
        t_out_byte          due_bytes [$];
        int                 n_fail;

        function new();
            wpos     = '0;
            owed     = '0;
            made     = '0;
            flag_sr  = '0;
            flag_cnt = '0;
            phase    = ST_IDLE;
            ref_b0   = '0;
            n_fail   = 0;
            foreach (hist[i]) hist[i] = '0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            n_fail++;
        endtask

        // one decoded byte into the window and the expected queue
        function void emit(logic [7:0] v, logic e);
            t_out_byte o;
            hist[wpos] = v;
            wpos++;
            if (made < WINDOW_DEPTH) made++;
            owed--;
            o.data = v;
            o.last = (owed == '0);
            o.err  = e;
            due_bytes.push_back(o);
        endfunction

        // where the parser goes once a token is done
        function void next_phase();
            if (owed == '0) phase = ST_IDLE;
            else if (flag_cnt == '0) phase = ST_FLAG;
            else phase = ST_TOKEN;
        endfunction

        // accepted input transaction: advance the parser, queue the bytes it yields
        function void take_stream_byte(logic [7:0] b, logic st);
            logic [4:0]        len;
            logic [12:0]       ref_dist;
            logic [WIN_AW-1:0] src;
            logic              is_ref;
            int                i;
            if (st) begin
                owed     = '0;
                made     = '0;
                wpos     = '0;
                flag_sr  = '0;
                flag_cnt = '0;
                ref_b0   = '0;
                phase    = ST_HDR1;
                return;
            end
            case (phase)
                ST_HDR1: begin
                    owed  = {16'd0, b};
                    phase = ST_HDR2;
                end
                ST_HDR2: begin
                    owed[15:8] = b;
                    phase      = ST_HDR3;
                end
                ST_HDR3: begin
                    owed[23:16] = b;
                    phase       = (owed == '0) ? ST_IDLE : ST_FLAG;
                end
                ST_FLAG: begin
                    flag_sr  = b;
                    flag_cnt = 4'd8;
                    phase    = ST_TOKEN;
                end
                ST_TOKEN: begin
                    is_ref   = flag_sr[7];
                    flag_sr  = {flag_sr[6:0], 1'b0};
                    flag_cnt = flag_cnt - 4'd1;
                    if (is_ref) begin
                        ref_b0 = b;
                        phase  = ST_REF2;
                    end else begin
                        emit(b, 1'b0);
                        next_phase();
                    end
                end
                ST_REF2: begin
                    len      = {1'b0, ref_b0[7:4]} + 5'd3;
                    ref_dist = {1'b0, ref_b0[3:0], b} + 13'd1;
                    // byte-wise copy, error checked per byte, cut at the size
                    for (i = 0; i < len && owed != '0; i++) begin
                        if (ref_dist > made) begin
                            emit(8'h00, 1'b1);
                        end else begin
                            src = wpos - ref_dist[WIN_AW-1:0];
                            emit(hist[src], 1'b0);
                        end
                    end
                    next_phase();
                end
                default: phase = ST_IDLE;
            endcase
        endfunction

        // accepted output transaction against the oldest expectation
        task check_out_byte(logic [7:0] d, logic l, logic e);
            t_out_byte x;
            if (due_bytes.size() == 0) begin
                report($sformatf("output byte %02h with nothing expected", d));
                return;
            end
            x = due_bytes.pop_front();
            if (d !== x.data) report($sformatf("byte %02h, expected %02h", d, x.data));
            if (l !== x.last) report($sformatf("last %b, expected %b", l, x.last));
            if (e !== x.err) report($sformatf("ref_error %b, expected %b", e, x.err));
        endtask

        function int waiting();
            return due_bytes.size();
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_in_byte      = '0;
    logic       i_stream_start = 1'b0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_ref_error;

    lz_decode_board board = new();
    int n_sent = 0;
    int n_got  = 0;
    int body_left = 0;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    lz77_byte_decompressor u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_ref_error    (o_ref_error)
    );

    // one input transaction, called and returning at a falling edge
    task automatic put_byte(input logic [7:0] b, input logic st);
        // random gaps, none in the steady stretch
        while (!(n_sent >= 120 && n_sent < 200) && $urandom_range(99) < 29) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_in_byte      = b;
        i_stream_start = st;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_stream_byte(b, st);
        n_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // stream body byte, dropped once the cut point is reached
    task automatic put_body(input logic [7:0] b);
        if (body_left > 0) begin
            put_byte(b, 1'b0);
            body_left--;
        end
    endtask

    // well-formed stream with random tokens, optionally cut short or followed by junk
    task automatic run_stream(input int unsigned size, input int ref_pct, input int far_pct,
                              input int len_lo, input int cut, input int junk);
        int unsigned made;
        logic [7:0]  flags;
        logic [11:0] dfield;
        logic [3:0]  nib;
        int          k;
        body_left = (cut > 0) ? cut : 32'h7fff_ffff;
        put_byte(8'($urandom), 1'b1);
        put_body(size[7:0]);
        put_body(size[15:8]);
        put_body(size[23:16]);
        made = 0;
        while (made < size && body_left > 0) begin
            for (k = 0; k < 8; k++) flags[k] = ($urandom_range(99) < ref_pct);
            put_body(flags);
            for (k = 7; k >= 0 && made < size; k--) begin
                if (flags[k]) begin
                    nib = 4'($urandom_range(15, len_lo));
                    // mostly near the bytes made so far, some far or wild
                    if ($urandom_range(99) < far_pct)
                        dfield = 12'($urandom_range(4095, 3900));
                    else if ($urandom_range(9) == 0)
                        dfield = 12'($urandom);
                    else
                        dfield = 12'($urandom_range(made < 4094 ? made + 1 : 4095));
                    put_body({nib, dfield[11:8]});
                    put_body(dfield[7:0]);
                    made += nib + 3;
                end else begin
                    put_body(8'($urandom));
                    made++;
                end
            end
        end
        repeat (junk) put_byte(8'($urandom), 1'b0);
    endtask

    task automatic wait_drained();
        while (board.waiting() != 0) @(negedge i_clk);
    endtask

    // sender
    initial begin
        int r;
        int guard;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // byte while idle after reset, ignored
        put_byte(8'hC3, 1'b0);
        // zero size stream, then a byte that is ignored
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hAA, 1'b0);
        // size 12: literal, reference that turns valid midway, literal, copy cut at size
        put_byte(8'h10, 1'b1);
        put_byte(8'h0C, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h50, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hF0, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h55, 1'b0);
        // largest size, longest copy at largest distance, all errors
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        // restart mid-stream, one literal
        put_byte(8'h7F, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h80, 1'b0);
        wait_drained();

        // random streams, mostly well formed
        while (n_sent < 240) begin
            r = $urandom_range(99);
            if (r < 8)
                run_stream($urandom_range(3), 50, 0, 0, 0, $urandom_range(2));
            else if (r < 80)
                run_stream($urandom_range(64, 1), $urandom_range(80), 0, 0, 0,
                           ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
            else if (r < 92)
                run_stream($urandom_range(24'hFFFFFF), $urandom_range(70), 0, 0,
                           $urandom_range(12, 1), 0);
            else
                repeat ($urandom_range(4, 1)) put_byte(8'($urandom), 1'b0);
        end
        wait_drained();

        // one long stream: long copies and far references
        run_stream(1500 + $urandom_range(100), 95, 30, 13, 0, 1);

        // drain and finish
        i_in_valid = 1'b0;
        guard = 0;
        while (board.waiting() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
        if (board.waiting() != 0)
            board.report($sformatf("%0d expected bytes never came", board.waiting()));
        if (board.n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, one long hold-off, one steady stretch
    initial begin
        int hold;
        bit hold_done;
        hold      = 0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold > 0) begin
                i_out_ready = 1'b0;
                hold--;
            end else if (!hold_done && n_got >= 60) begin
                hold_done   = 1'b1;
                hold        = 300;
                i_out_ready = 1'b0;
            end else if (n_got >= 400 && n_got < 700) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = ($urandom_range(99) >= 29);
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                board.check_out_byte(o_out_byte, o_out_last, o_ref_error);
                n_got++;
            end
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
